[sv/cpu_pkg.sv]
// shared types, format codes and divider step for the cursor pixel unpremultiply block
`default_nettype none

package cpu_pkg;

    // source layout codes of the format register
    typedef enum logic [2:0] {
        FMT_ARGB = 3'd0,
        FMT_XRGB = 3'd1,
        FMT_RGBA = 3'd2,
        FMT_RGBX = 3'd3,
        FMT_ABGR = 3'd4,
        FMT_XBGR = 3'd5
    } cpu_fmt_t;

    localparam int unsigned BYTE_W         = 8;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hff;
    localparam logic [7:0]  COLOR_SAT      = 8'hff;
    localparam int unsigned QUO_BITS       = 8;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES     = QUO_BITS / BITS_PER_STAGE;
    localparam int unsigned NUM_LANES      = 3;
    localparam int unsigned LANE_RED       = 0;
    localparam int unsigned LANE_GREEN     = 1;
    localparam int unsigned LANE_BLUE      = 2;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       premul;
        logic       last;
    } cpu_item_t;

    // one colour lane inside the divider pipeline
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
        logic       sat;
    } cpu_lane_t;

    typedef struct packed {
        cpu_lane_t [NUM_LANES-1:0] lane;
        logic [7:0]                alpha;
        logic                      premul;
        logic                      zero;
        logic                      last;
    } cpu_work_t;

    // one restoring division step: brings in the next dividend bit
    function automatic cpu_lane_t div_step(input cpu_lane_t l, input logic [7:0] a);
        cpu_lane_t  r;
        logic [8:0] t;
        logic [8:0] d;
        r = l;
        t = {l.rem, l.low[7]};
        d = t - {1'b0, a};
        r.low = {l.low[6:0], 1'b0};
        if (t >= {1'b0, a})
        begin
            r.rem = d[7:0];
            r.quo = {l.quo[6:0], 1'b1};
        end
        else
        begin
            r.rem = t[7:0];
            r.quo = {l.quo[6:0], 1'b0};
        end
        return r;
    endfunction

    // lane setup: dividend c*255 split into high remainder and low bits
    function automatic cpu_lane_t lane_setup(input logic [7:0] c, input logic [7:0] a);
        cpu_lane_t   r;
        logic [15:0] n;
        n = {c, 8'd0} - {8'd0, c};
        r.color = c;
        r.rem   = n[15:8];
        r.low   = n[7:0];
        r.quo   = '0;
        r.sat   = (c >= a);
        return r;
    endfunction

    function automatic logic [7:0] lane_result(input cpu_lane_t l, input logic premul,
                                               input logic zero);
        logic [7:0] r;
        if (!premul)
            r = l.color;
        else if (zero)
            r = '0;
        else if (l.sat)
            r = COLOR_SAT;
        else
            r = l.quo;
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/cursor_pixel_unpremultiply.sv]
// top level of the cursor pixel swizzle and alpha unpremultiply block
// path: queue, setup stage, divider stages, result register; held results stall the pipe
// throughput: one item per cycle when not stalled; each of four divider stages resolves
// two quotient bits per colour lane, so the three lanes never loop back on themselves
// the queue holds QUEUE_DEPTH items, so push continues while a result waits, until full
// reset: rst_n async low clears queue, pipe valids and result flag; format resets to ARGB
`default_nettype none

module cursor_pixel_unpremultiply #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // format register write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_data,
    // input item side
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] byte_0,
    input  wire logic [7:0] byte_1,
    input  wire logic [7:0] byte_2,
    input  wire logic [7:0] byte_3,
    input  wire logic       last_pixel,
    // result item side
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic [7:0]      alpha,
    output logic            last_out
);
    import cpu_pkg::*;

    cpu_item_t wr_item;
    cpu_item_t rd_item;
    logic      q_wr;
    logic      q_rd;
    logic      q_empty;

    // front swizzles bytes into r/g/b/a and flags items that need unpremultiply
    cpu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .q_full     (full),
        .byte_0     (byte_0),
        .byte_1     (byte_1),
        .byte_2     (byte_2),
        .byte_3     (byte_3),
        .last_pixel (last_pixel),
        .q_wr       (q_wr),
        .q_item     (wr_item)
    );

    // decouples the front from divider stalls; full here is the block's full
    cpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_item (wr_item),
        .full    (full),
        .rd_en   (q_rd),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    // back runs the divider lanes, saturates, and holds the oldest result
    cpu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (rd_item),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha),
        .last_out (last_out)
    );

endmodule

`default_nettype wire

[sv/cpu_front.sv]
// front: format register, byte swizzle and alpha classification
`default_nettype none

module cpu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_data,
    input  wire logic              push,
    input  wire logic              q_full,
    input  wire logic [7:0]        byte_0,
    input  wire logic [7:0]        byte_1,
    input  wire logic [7:0]        byte_2,
    input  wire logic [7:0]        byte_3,
    input  wire logic              last_pixel,
    output logic                   q_wr,
    output cpu_pkg::cpu_item_t     q_item
);
    import cpu_pkg::*;

    logic [2:0] fmt_reg;
    logic [2:0] fmt_next;

    assign cfg_ready = 1'b1;
    assign fmt_next  = (cfg_valid && cfg_ready) ? cfg_data : fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_ARGB;
        else
            fmt_reg <= fmt_next;
    end

    assign q_wr = push && !q_full;

    always_comb
    begin
        q_item        = '0;
        q_item.last   = last_pixel;
        case (fmt_reg)
            FMT_ARGB:
            begin
                q_item.blue = byte_0; q_item.green = byte_1;
                q_item.red = byte_2; q_item.alpha = byte_3;
                q_item.premul = 1'b1;
            end
            FMT_XRGB:
            begin
                q_item.blue = byte_0; q_item.green = byte_1;
                q_item.red = byte_2; q_item.alpha = ALPHA_OPAQUE;
            end
            FMT_RGBA:
            begin
                q_item.alpha = byte_0; q_item.blue = byte_1;
                q_item.green = byte_2; q_item.red = byte_3;
                q_item.premul = 1'b1;
            end
            FMT_RGBX:
            begin
                q_item.blue = byte_1; q_item.green = byte_2;
                q_item.red = byte_3; q_item.alpha = ALPHA_OPAQUE;
            end
            FMT_ABGR:
            begin
                q_item.red = byte_0; q_item.green = byte_1;
                q_item.blue = byte_2; q_item.alpha = byte_3;
                q_item.premul = 1'b1;
            end
            FMT_XBGR:
            begin
                q_item.red = byte_0; q_item.green = byte_1;
                q_item.blue = byte_2; q_item.alpha = ALPHA_OPAQUE;
            end
            default:
            begin
                // unused codes give all-zero colour and alpha
                q_item.premul = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/cpu_queue.sv]
// short queue between front and back
`default_nettype none

module cpu_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire cpu_pkg::cpu_item_t wr_item,
    output logic                    full,
    input  wire logic               rd_en,
    output cpu_pkg::cpu_item_t      rd_item,
    output logic                    empty
);
    import cpu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cpu_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !empty)
        else $error("queue read while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count lost an item");

endmodule

`default_nettype wire

[sv/cpu_back.sv]
// back: pipelined divider lanes for c*255/alpha and the result register
`default_nettype none

module cpu_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire cpu_pkg::cpu_item_t q_item,
    output logic                    q_rd,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic [7:0]              alpha,
    output logic                    last_out
);
    import cpu_pkg::*;

    logic [DIV_STAGES:0] valid_reg;
    cpu_work_t           work_reg  [DIV_STAGES+1];
    cpu_work_t           work_next [DIV_STAGES+1];
    logic                out_valid_reg;
    logic [7:0]          red_reg, green_reg, blue_reg, alpha_reg;
    logic                last_reg;
    logic                adv;

    // whole pipe moves when the result register is free or being taken
    assign adv  = !out_valid_reg || pop;
    assign q_rd = adv && !q_empty;

    always_comb
    begin
        cpu_work_t w;
        w = '0;
        work_next[0]        = '0;
        work_next[0].alpha  = q_item.alpha;
        work_next[0].premul = q_item.premul;
        work_next[0].zero   = (q_item.alpha == '0);
        work_next[0].last   = q_item.last;
        work_next[0].lane[LANE_RED]   = lane_setup(q_item.red,   q_item.alpha);
        work_next[0].lane[LANE_GREEN] = lane_setup(q_item.green, q_item.alpha);
        work_next[0].lane[LANE_BLUE]  = lane_setup(q_item.blue,  q_item.alpha);
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            w = work_reg[s-1];
            for (int k = 0; k < BITS_PER_STAGE; k++)
            begin
                for (int l = 0; l < NUM_LANES; l++)
                    w.lane[l] = div_step(w.lane[l], w.alpha);
            end
            work_next[s] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[DIV_STAGES-1:0], !q_empty};
            out_valid_reg <= valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
                work_reg[s] <= work_next[s];
            red_reg   <= lane_result(work_reg[DIV_STAGES].lane[LANE_RED],
                                     work_reg[DIV_STAGES].premul, work_reg[DIV_STAGES].zero);
            green_reg <= lane_result(work_reg[DIV_STAGES].lane[LANE_GREEN],
                                     work_reg[DIV_STAGES].premul, work_reg[DIV_STAGES].zero);
            blue_reg  <= lane_result(work_reg[DIV_STAGES].lane[LANE_BLUE],
                                     work_reg[DIV_STAGES].premul, work_reg[DIV_STAGES].zero);
            alpha_reg <= work_reg[DIV_STAGES].alpha;
            last_reg  <= work_reg[DIV_STAGES].last;
        end
    end

    assign empty    = !out_valid_reg;
    assign red      = red_reg;
    assign green    = green_reg;
    assign blue     = blue_reg;
    assign alpha    = alpha_reg;
    assign last_out = last_reg;

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> $stable(valid_reg))
        else $error("divider pipe moved while result was held");
    a_tail_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[DIV_STAGES] && adv) |=> out_valid_reg)
        else $error("item dropped at result register");
    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (!out_valid_reg || pop))
        else $error("queue read while pipe stalled");

endmodule

`default_nettype wire
